### src/assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### src/cossim_pkg.sv
`default_nettype none

package cossim_pkg;

    // Element and accumulator widths
    localparam int ELEM_W     = 16;
    localparam int MUL_W      = 2 * ELEM_W;
    localparam int SUM_W      = 48;
    localparam int HALF_W     = SUM_W / 2;
    localparam int PROD_W     = 2 * SUM_W;

    // Root search: 16 result bits, candidate compare width
    localparam int ROOT_W     = 16;
    localparam int ROOT_IDX_W = $clog2(ROOT_W);
    localparam int CAND_W     = PROD_W + 2 * ROOT_W;
    localparam int QACC_W     = PROD_W + ROOT_W;
    localparam int FRAC_SHIFT = 30;

    // Result width
    localparam int RES_W      = 16;

    // Partial products: 4 for sumA*sumB, 4 for dot*dot
    localparam int MUL_STEPS  = 8;
    localparam int STEP_W     = $clog2(MUL_STEPS + 1);

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_a;
        logic signed [ELEM_W-1:0] elem_b;
        logic                     last_elem;
    } t_in_item;

    typedef struct packed {
        logic signed [RES_W-1:0] cosine;
        logic                    zero_norm;
    } t_out_item;

    typedef enum logic [4:0] {
        S_ACC   = 5'b00001,
        S_DRAIN = 5'b00010,
        S_MULT  = 5'b00100,
        S_ROOT  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // Operand select for one partial product
    typedef struct packed {
        logic dot;
        logic hi_x;
        logic hi_y;
    } t_pp_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic                  s1_load;
        logic                  s2_add;
        logic                  fin_clear;
        logic                  mul_go;
        t_pp_sel               mul_sel;
        logic                  pp_add;
        t_pp_sel               pp_sel;
        logic                  cand_calc;
        logic                  cand_test;
        logic [ROOT_IDX_W-1:0] bit_idx;
        logic                  load_out;
        logic                  sum_clear;
    } t_cmd;

endpackage

`default_nettype wire

### src/cossim_ctrl.sv
`default_nettype none

module cossim_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_last,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output cossim_pkg::t_cmd       o_cmd
);

    cossim_pkg::t_state                   r_state, n_state;
    logic [cossim_pkg::STEP_W-1:0]        r_cnt, n_cnt;
    logic [cossim_pkg::ROOT_IDX_W-1:0]    r_bit, n_bit;
    logic                                 r_phase, n_phase;
    logic                                 r_s1_vld;
    logic                                 r_pp_vld;
    cossim_pkg::t_pp_sel                  r_pp_sel;
    logic                                 r_out_vld;
    logic                                 in_fire;
    logic                                 out_free;
    logic                                 mul_go;
    logic                                 load_out;

    assign in_fire  = i_in_valid && (r_state == cossim_pkg::S_ACC);
    assign out_free = !r_out_vld || !i_out_stall;
    assign mul_go   = (r_state == cossim_pkg::S_MULT) &&
                      (r_cnt < cossim_pkg::STEP_W'(cossim_pkg::MUL_STEPS));
    assign load_out = (r_state == cossim_pkg::S_DONE) && out_free;

    // Next state and counters
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bit   = r_bit;
        n_phase = r_phase;
        unique case (r_state)
            cossim_pkg::S_ACC: begin
                if (in_fire && i_in_last) begin
                    n_state = cossim_pkg::S_DRAIN;
                end
            end
            cossim_pkg::S_DRAIN: begin
                n_cnt   = '0;
                n_bit   = '1;
                n_phase = 1'b0;
                n_state = cossim_pkg::S_MULT;
            end
            cossim_pkg::S_MULT: begin
                if (r_cnt == cossim_pkg::STEP_W'(cossim_pkg::MUL_STEPS)) begin
                    n_state = cossim_pkg::S_ROOT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            cossim_pkg::S_ROOT: begin
                n_phase = !r_phase;
                if (r_phase) begin
                    if (r_bit == '0) begin
                        n_state = cossim_pkg::S_DONE;
                    end else begin
                        n_bit = r_bit - 1'b1;
                    end
                end
            end
            cossim_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = cossim_pkg::S_ACC;
                end
            end
            default: begin
                n_state = cossim_pkg::S_ACC;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cossim_pkg::S_ACC;
            r_cnt     <= '0;
            r_bit     <= '0;
            r_phase   <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_pp_vld  <= 1'b0;
            r_pp_sel  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_bit    <= n_bit;
            r_phase  <= n_phase;
            r_s1_vld <= in_fire;
            r_pp_vld <= mul_go;
            r_pp_sel <= cossim_pkg::t_pp_sel'(r_cnt[2:0]);
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Command word
    always_comb begin
        o_cmd           = '0;
        o_cmd.s1_load   = in_fire;
        o_cmd.s2_add    = r_s1_vld;
        o_cmd.fin_clear = (r_state == cossim_pkg::S_DRAIN);
        o_cmd.mul_go    = mul_go;
        o_cmd.mul_sel   = cossim_pkg::t_pp_sel'(r_cnt[2:0]);
        o_cmd.pp_add    = r_pp_vld;
        o_cmd.pp_sel    = r_pp_sel;
        o_cmd.cand_calc = (r_state == cossim_pkg::S_ROOT) && !r_phase;
        o_cmd.cand_test = (r_state == cossim_pkg::S_ROOT) && r_phase;
        o_cmd.bit_idx   = r_bit;
        o_cmd.load_out  = load_out;
        o_cmd.sum_clear = load_out;
    end

    assign o_in_stall  = (r_state != cossim_pkg::S_ACC);
    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

### src/cossim_dp.sv
`default_nettype none

module cossim_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire cossim_pkg::t_in_item i_in_data,
    input  wire cossim_pkg::t_cmd     i_cmd,
    output cossim_pkg::t_out_item     o_out_data
);

    localparam int SUM_W  = cossim_pkg::SUM_W;
    localparam int MUL_W  = cossim_pkg::MUL_W;
    localparam int HALF_W = cossim_pkg::HALF_W;
    localparam int PROD_W = cossim_pkg::PROD_W;
    localparam int CAND_W = cossim_pkg::CAND_W;
    localparam int QACC_W = cossim_pkg::QACC_W;
    localparam int ROOT_W = cossim_pkg::ROOT_W;
    localparam int RES_W  = cossim_pkg::RES_W;
    localparam int IDX_W  = cossim_pkg::ROOT_IDX_W;

    localparam logic [SUM_W-1:0] DOT_MAX     = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] DOT_MIN     = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [RES_W-1:0] RES_POS_MAX = {1'b0, {(RES_W-1){1'b1}}};
    localparam logic [RES_W-1:0] RES_NEG_MIN = {1'b1, {(RES_W-1){1'b0}}};

    // Stage 1: element products
    logic signed [cossim_pkg::ELEM_W-1:0] a_s, b_s;
    logic signed [MUL_W-1:0]              ab_p, aa_p, bb_p;
    logic [MUL_W-1:0]                     r_ab, r_aa, r_bb;

    // Stage 2: saturating running sums
    logic [SUM_W-1:0] r_dot, r_sa, r_sb;
    logic [SUM_W-1:0] n_dot, n_sa, n_sb;
    logic [SUM_W:0]   dot_wide, sa_wide, sb_wide;

    // Final multiply
    logic [SUM_W-1:0]  r_magd;
    logic [SUM_W-1:0]  opx, opy;
    logic [HALF_W-1:0] mx, my;
    logic [SUM_W-1:0]  r_pp;
    logic [1:0]        pp_pos;
    logic [PROD_W-1:0] pp_shifted;
    logic [PROD_W-1:0] r_prod, r_dsq;

    // Root search
    logic [CAND_W-1:0] r_p, r_cand, cand, rhs;
    logic [QACC_W-1:0] r_q;
    logic [ROOT_W-1:0] r_m;
    logic [IDX_W:0]    sh_q, sh_p;

    // Result
    logic              neg;
    logic              zero;
    logic [ROOT_W-1:0] m_neg;
    cossim_pkg::t_out_item n_out, r_out;

    assign a_s  = i_in_data.elem_a;
    assign b_s  = i_in_data.elem_b;
    assign ab_p = a_s * b_s;
    assign aa_p = a_s * a_s;
    assign bb_p = b_s * b_s;

    always_ff @(posedge i_clk) begin
        if (i_cmd.s1_load) begin
            r_ab <= ab_p;
            r_aa <= aa_p;
            r_bb <= bb_p;
        end
    end

    // Sums widened by one bit, then clamped
    assign dot_wide = {r_dot[SUM_W-1], r_dot} +
                      {{(SUM_W+1-MUL_W){r_ab[MUL_W-1]}}, r_ab};
    assign sa_wide  = {1'b0, r_sa} + (SUM_W+1)'(r_aa);
    assign sb_wide  = {1'b0, r_sb} + (SUM_W+1)'(r_bb);

    always_comb begin
        priority if (!dot_wide[SUM_W] && dot_wide[SUM_W-1]) begin
            n_dot = DOT_MAX;
        end else if (dot_wide[SUM_W] && !dot_wide[SUM_W-1]) begin
            n_dot = DOT_MIN;
        end else begin
            n_dot = dot_wide[SUM_W-1:0];
        end
        n_sa = sa_wide[SUM_W] ? '1 : sa_wide[SUM_W-1:0];
        n_sb = sb_wide[SUM_W] ? '1 : sb_wide[SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
            r_sa  <= '0;
            r_sb  <= '0;
        end else if (i_cmd.sum_clear) begin
            r_dot <= '0;
            r_sa  <= '0;
            r_sb  <= '0;
        end else if (i_cmd.s2_add) begin
            r_dot <= n_dot;
            r_sa  <= n_sa;
            r_sb  <= n_sb;
        end
    end

    // |dot| tracks the sum; settled before the dot partial products start
    always_ff @(posedge i_clk) begin
        r_magd <= r_dot[SUM_W-1] ? (~r_dot + 1'b1) : r_dot;
    end

    // One half-by-half product per cycle
    assign opx = i_cmd.mul_sel.dot ? r_magd : r_sa;
    assign opy = i_cmd.mul_sel.dot ? r_magd : r_sb;
    assign mx  = i_cmd.mul_sel.hi_x ? opx[SUM_W-1:HALF_W] : opx[HALF_W-1:0];
    assign my  = i_cmd.mul_sel.hi_y ? opy[SUM_W-1:HALF_W] : opy[HALF_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_go) begin
            r_pp <= mx * my;
        end
    end

    // Align the registered partial product by its half positions
    assign pp_pos = {1'b0, i_cmd.pp_sel.hi_x} + {1'b0, i_cmd.pp_sel.hi_y};

    always_comb begin
        unique case (pp_pos)
            2'd0:    pp_shifted = PROD_W'(r_pp);
            2'd1:    pp_shifted = PROD_W'(r_pp) << HALF_W;
            2'd2:    pp_shifted = PROD_W'(r_pp) << (2 * HALF_W);
            default: pp_shifted = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_clear) begin
            r_prod <= '0;
            r_dsq  <= '0;
        end else if (i_cmd.pp_add) begin
            if (i_cmd.pp_sel.dot) begin
                r_dsq <= r_dsq + pp_shifted;
            end else begin
                r_prod <= r_prod + pp_shifted;
            end
        end
    end

    // Trial t = m + 2^k: prod*t^2 = P + (Q << (k+1)) + (prod << 2k), Q = prod*m
    assign sh_q = {1'b0, i_cmd.bit_idx} + 1'b1;
    assign sh_p = {i_cmd.bit_idx, 1'b0};
    assign cand = r_p + (CAND_W'(r_q) << sh_q) + (CAND_W'(r_prod) << sh_p);
    assign rhs  = {{(CAND_W-PROD_W-cossim_pkg::FRAC_SHIFT){1'b0}}, r_dsq,
                   {cossim_pkg::FRAC_SHIFT{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_clear) begin
            r_p <= '0;
            r_q <= '0;
            r_m <= '0;
        end else if (i_cmd.cand_test) begin
            if (r_cand <= rhs) begin
                r_p           <= r_cand;
                r_q           <= r_q + (QACC_W'(r_prod) << i_cmd.bit_idx);
                r_m[i_cmd.bit_idx] <= 1'b1;
            end
        end
        if (i_cmd.cand_calc) begin
            r_cand <= cand;
        end
    end

    // Sign, saturation and zero-norm handling
    assign neg   = r_dot[SUM_W-1];
    assign zero  = (r_sa == '0) || (r_sb == '0);
    assign m_neg = ~r_m + 1'b1;

    always_comb begin
        n_out = '0;
        priority if (zero) begin
            n_out.zero_norm = 1'b1;
        end else if (neg) begin
            n_out.cosine = (r_m > ROOT_W'(RES_NEG_MIN)) ? RES_NEG_MIN : RES_W'(m_neg);
        end else begin
            n_out.cosine = (r_m > ROOT_W'(RES_POS_MAX)) ? RES_POS_MAX : RES_W'(r_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

### src/cosine_similarity_top.sv
// Cosine similarity of two streamed vectors, signed Q1.15 in and out.
// Input channel: one element pair per transaction (i_in_valid / o_in_stall);
// last_elem marks the final pair of a vector. Pairs are taken one per cycle
// while a vector streams in; three saturating 48-bit sums collect a*b, a*a, b*b.
// After the last pair, input stays stalled while one 24x24 multiplier forms
// sumA*sumB and dot^2 in 8 partial products, then a bit-serial root search
// finds the 16 result bits, each with a candidate step and a test step.
// The input stays stalled until the result is loaded into the output register.
// Output channel: one transaction per vector (o_out_valid / i_out_stall).
// The output register holds a result while the receiver stalls; the next vector
// streams in meanwhile, and only its final result waits for the register.
// Zero norm on either side gives cosine 0 with zero_norm set.
// Reset (i_rst_n low, synchronous) clears the sums, control and output valid.
`default_nettype none

`include "assert_macros.svh"

module cosine_similarity_top (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire cossim_pkg::t_in_item  i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output cossim_pkg::t_out_item      o_out_data
);

    cossim_pkg::t_cmd cmd;

    // Sequencer
    cossim_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.last_elem),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Accumulators, multiplier and root search
    cossim_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_out_data (o_out_data)
    );

    // The cycle after the last pair is taken, input must be stalled
    `ASSERT_PROP(a_last_stalls, i_clk, i_rst_n, (i_in_valid && !o_in_stall && i_in_data.last_elem) |=> o_in_stall)

    // Zero norm always reports a zero cosine
    `ASSERT_NEVER(a_zero_norm_value, i_clk, i_rst_n, o_out_valid && o_out_data.zero_norm && (o_out_data.cosine != '0))

    // A new result only follows a busy cycle
    `ASSERT_PROP(a_result_after_busy, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall))

endmodule

`default_nettype wire
